// ----- rtl/core/fcm_pkg.sv -----
// Shared types and constants for the fuzzy c-means membership classifier.
`timescale 1ns / 1ps
package fcm_pkg;

    localparam int NumClusters = 4;
    localparam int NumFeatures = 3;
    localparam int NumCfgRegs  = 6;
    localparam int DefBatchSize = 2048;

    typedef struct packed {
        logic signed [31:0] feature_magnitude;
        logic signed [31:0] feature_phase;
        logic signed [31:0] feature_third;
        logic [2:0]         true_label;
        logic               start_batch;
    } sample_t;

    typedef struct packed {
        logic [16:0] membership_0;
        logic [16:0] membership_1;
        logic [16:0] membership_2;
        logic [16:0] membership_3;
        logic [1:0]  best_cluster;
        logic [10:0] cluster_slot;
        logic        label_match;
        logic [11:0] match_count;
        logic [11:0] sample_count;
    } result_t;

    // Request to the shared serial divider.
    typedef struct packed {
        logic        start;
        logic [64:0] dividend;
        logic [64:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [64:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/fcm_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fcm_divider
(
    input  logic             clk,
    input  logic             rst_n,
    input  fcm_pkg::div_req_t req,
    output fcm_pkg::div_rsp_t rsp
);
    import fcm_pkg::*;

    logic [64:0] quot_reg, quot_next;
    logic [64:0] rem_reg, rem_next;
    logic [64:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[64]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd65;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[65])
            begin
                rem_next  = trial[64:0];
                quot_next = {quot_reg[63:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[63:0], quot_reg[64]};
                quot_next = {quot_reg[63:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

// ----- rtl/core/fcm_squarer.sv -----
// Serial squarer: a*a by shift-and-add, four multiplier bits per cycle.
`timescale 1ns / 1ps
module fcm_squarer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        done,
    output logic [63:0] square
);
    import fcm_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] partial;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        partial     = 36'(mcand_reg) * 36'(mplier_reg[3:0]);
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = operand;
            mplier_next = operand;
            cnt_next    = 4'd8;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // newest digit lands at the top; shift right each step
            acc_next    = {4'd0, acc_reg[63:4]}
                          + {partial, 28'd0};
            mplier_next = {4'd0, mplier_reg[31:4]};
            cnt_next    = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // after eight steps the first digit has reached bit 0: full product
    assign square = acc_reg;
    assign done   = done_reg;
endmodule

// ----- rtl/core/fuzzy_cmeans_membership_classifier.sv -----
// Top level: fuzzy c-means (m = 2) membership classifier, four clusters.
//
// Usage: samples arrive on in_valid/in_stall as a packed sample_t request;
// results leave on out_valid/out_stall as a packed result_t. Centers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data while idle; index
// i holds center coordinates 2i (low half) and 2i+1 (high half).
// One sample is worked at a time. From acceptance to out_valid the block
// runs twelve serial squarings, a minimum step, eight divisions (four for
// the ratios, four for rounding) on one shared radix-2 divider, and a
// finishing step. It takes a new sample only once the result has left.
// A sample on a center skips all divisions; a squared distance that is
// zero once scaled down by four skips the ratios.
// in_stall is high from acceptance until the result is taken.
// The result sits in an output register until out_stall is low; the block
// takes no new sample meanwhile. Reset clears centers, counters and all
// control state; no result is pending after reset.
`timescale 1ns / 1ps
module fuzzy_cmeans_membership_classifier
#(
    parameter int BATCH_SIZE = fcm_pkg::DefBatchSize
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fcm_pkg::sample_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output fcm_pkg::result_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import fcm_pkg::*;

    localparam int CountCap = (BATCH_SIZE > 4095) ? 4095 : BATCH_SIZE;
    localparam int SlotCap  = ((BATCH_SIZE - 1) > 2047) ? 2047 : (BATCH_SIZE - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_START, S_SQ_WAIT, S_MIN, S_DIV_START, S_DIV_WAIT,
        S_RND_START, S_RND_WAIT, S_FINISH, S_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] center_reg [NumCfgRegs];
    sample_t     smp_reg;
    logic [63:0] dist_reg [NumClusters];
    logic [NumClusters-1:0] hit_reg;
    logic [1:0]  ci_reg;
    logic [1:0]  fi_reg;
    logic [63:0] mm_reg;
    logic [32:0] q_reg [NumClusters];
    logic [34:0] total_reg;
    logic [16:0] u_reg [NumClusters];
    logic [10:0] slot_reg [NumClusters];
    logic [11:0] matches_reg, samples_reg;
    logic [5:0]  shift_reg;
    result_t     res_reg;

    logic        sq_start, sq_done;
    logic [63:0] sq_out;
    logic [31:0] sq_operand;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [3:0]         coord_idx;
    logic signed [32:0] feat_sel, cen_sel, diff;
    logic [63:0]        cmin;
    logic [6:0]         mlen;
    logic [63:0]        e_sel;

    always_comb
    begin
        coord_idx = 4'(ci_reg) * 4'd3 + 4'(fi_reg);
        case (fi_reg)
            2'd0:    feat_sel = 33'(smp_reg.feature_magnitude);
            2'd1:    feat_sel = 33'(smp_reg.feature_phase);
            default: feat_sel = 33'(smp_reg.feature_third);
        endcase
        if (coord_idx[0])
            cen_sel = 33'(signed'(center_reg[coord_idx[3:1]][63:32]));
        else
            cen_sel = 33'(signed'(center_reg[coord_idx[3:1]][31:0]));
        diff = feat_sel - cen_sel;
        sq_operand = diff[32] ? 32'(-diff) : diff[31:0];
        cmin = dist_reg[0];
        for (int k = 1; k < NumClusters; k++)
            if (dist_reg[k] < cmin)
                cmin = dist_reg[k];
        mlen = 7'd0;
        for (int b = 0; b < 64; b++)
            if (cmin[b])
                mlen = 7'(b + 1);
        e_sel = dist_reg[ci_reg] >> shift_reg;
    end

    fcm_squarer u_sq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_operand),
        .done    (sq_done),
        .square  (sq_out)
    );

    fcm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign sq_start  = (state_reg == S_SQ_START);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, mm_reg[31:0], 32'd0};
        div_req.divisor  = {1'b0, e_sel};
        if (state_reg == S_DIV_START)
            div_req.start = (e_sel != 64'd0);
        else if (state_reg == S_RND_START)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = 65'({q_reg[ci_reg], 16'd0}) + 65'(total_reg[34:1]);
            div_req.divisor  = 65'(total_reg);
        end
    end

    logic [1:0]  best;
    logic [10:0] slot_now;
    logic        match;
    logic [11:0] mt_base, sp_base;

    always_comb
    begin
        best = 2'd0;
        for (int k = 0; k < NumClusters; k++)
            if (u_reg[k] >= u_reg[best])
                best = 2'(k);
        match    = (smp_reg.true_label != 3'd0) && ({1'b0, best} == smp_reg.true_label - 3'd1);
        slot_now = smp_reg.start_batch ? 11'd0 : slot_reg[best];
        mt_base  = smp_reg.start_batch ? 12'd0 : matches_reg;
        sp_base  = smp_reg.start_batch ? 12'd0 : samples_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int k = 0; k < NumCfgRegs; k++)
                center_reg[k] <= '0;
            for (int k = 0; k < NumClusters; k++)
                slot_reg[k] <= '0;
            matches_reg <= '0;
            samples_reg <= '0;
            ci_reg      <= '0;
            fi_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_index < 3'(NumCfgRegs))
                        center_reg[cfg_index] <= cfg_data;
                    if (in_valid)
                    begin
                        ci_reg    <= '0;
                        fi_reg    <= '0;
                        state_reg <= S_SQ_START;
                    end
                end
                S_SQ_START:
                    state_reg <= S_SQ_WAIT;
                S_SQ_WAIT:
                begin
                    if (sq_done)
                    begin
                        if (fi_reg == 2'd2)
                        begin
                            fi_reg <= '0;
                            ci_reg <= ci_reg + 2'd1;
                            state_reg <= (ci_reg == 2'd3) ? S_MIN : S_SQ_START;
                        end
                        else
                        begin
                            fi_reg    <= fi_reg + 2'd1;
                            state_reg <= S_SQ_START;
                        end
                    end
                end
                S_MIN:
                begin
                    ci_reg <= '0;
                    if (hit_reg != '0)
                        state_reg <= S_FINISH;
                    else if (cmin == 64'd0)
                        state_reg <= S_RND_START;
                    else
                        state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    if (e_sel != 64'd0)
                        state_reg <= S_DIV_WAIT;
                    else
                    begin
                        // zero divisor: ratio stays zero, move on
                        ci_reg    <= ci_reg + 2'd1;
                        state_reg <= (ci_reg == 2'd3) ? S_RND_START : S_DIV_START;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ci_reg    <= ci_reg + 2'd1;
                        state_reg <= (ci_reg == 2'd3) ? S_RND_START : S_DIV_START;
                    end
                end
                S_RND_START:
                    state_reg <= (total_reg == 35'd0) ? S_FINISH : S_RND_WAIT;
                S_RND_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        ci_reg    <= ci_reg + 2'd1;
                        state_reg <= (ci_reg == 2'd3) ? S_FINISH : S_RND_START;
                    end
                end
                S_FINISH:
                begin
                    for (int k = 0; k < NumClusters; k++)
                        if (2'(k) == best)
                            slot_reg[k] <= (slot_now < 11'(SlotCap)) ? slot_now + 11'd1
                                                                     : slot_now;
                        else if (smp_reg.start_batch)
                            slot_reg[k] <= '0;
                    matches_reg <= (match && mt_base < 12'(CountCap)) ? mt_base + 12'd1 : mt_base;
                    samples_reg <= (sp_base < 12'(CountCap)) ? sp_base + 12'd1 : sp_base;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            smp_reg   <= in_data;
            hit_reg   <= '1;
            total_reg <= '0;
            for (int k = 0; k < NumClusters; k++)
            begin
                dist_reg[k] <= '0;
                q_reg[k]    <= '0;
                u_reg[k]    <= '0;
            end
        end
        if (state_reg == S_SQ_START && sq_operand != 32'd0)
            hit_reg[ci_reg] <= 1'b0;
        if (state_reg == S_SQ_WAIT && sq_done)
            dist_reg[ci_reg] <= dist_reg[ci_reg] + {2'd0, sq_out[63:2]};
        if (state_reg == S_MIN)
        begin
            shift_reg <= (mlen > 7'd32) ? 6'(mlen - 7'd32) : 6'd0;
            mm_reg    <= (mlen > 7'd32) ? (cmin >> (mlen - 7'd32)) : cmin;
            if (hit_reg != '0)
            begin
                for (int k = 0; k < NumClusters; k++)
                    u_reg[k] <= '0;
                if (hit_reg[3])      u_reg[3] <= 17'd65536;
                else if (hit_reg[2]) u_reg[2] <= 17'd65536;
                else if (hit_reg[1]) u_reg[1] <= 17'd65536;
                else                 u_reg[0] <= 17'd65536;
            end
            else if (cmin == 64'd0)
            begin
                for (int k = 0; k < NumClusters; k++)
                    q_reg[k] <= (dist_reg[k] == 64'd0) ? 33'h1_0000_0000 : 33'd0;
                total_reg <= {2'd0, (dist_reg[0] == 64'd0), 32'd0}
                             + {2'd0, (dist_reg[1] == 64'd0), 32'd0}
                             + {2'd0, (dist_reg[2] == 64'd0), 32'd0}
                             + {2'd0, (dist_reg[3] == 64'd0), 32'd0};
            end
        end
        if (state_reg == S_DIV_WAIT && div_rsp.done)
        begin
            q_reg[ci_reg] <= div_rsp.quotient[32:0];
            total_reg     <= total_reg + 35'(div_rsp.quotient[32:0]);
        end
        if (state_reg == S_RND_WAIT && div_rsp.done)
            u_reg[ci_reg] <= div_rsp.quotient[16:0];
        if (state_reg == S_FINISH)
        begin
            res_reg.membership_0 <= u_reg[0];
            res_reg.membership_1 <= u_reg[1];
            res_reg.membership_2 <= u_reg[2];
            res_reg.membership_3 <= u_reg[3];
            res_reg.best_cluster <= best;
            res_reg.cluster_slot <= slot_now;
            res_reg.label_match  <= match;
            res_reg.match_count  <= (match && mt_base < 12'(CountCap)) ? mt_base + 12'd1 : mt_base;
            res_reg.sample_count <= (sp_base < 12'(CountCap)) ? sp_base + 12'd1 : sp_base;
        end
    end
endmodule
